// ===== hw/rtl/scf_pkg.sv =====
// Shared types, constants and microcode table for the stereo crossfeed filter.
package scf_pkg;

	// Field and datapath widths
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int COEF_W          = 26;
	localparam int COEF_FRAC       = 22;
	localparam int STATE_W         = 32;
	localparam int MUL_B_W         = 33;                 // state + state, or a sample up to 32 bits
	localparam int PROD_W          = COEF_W + MUL_B_W;
	localparam int ACC_W           = PROD_W + 2;         // three products summed
	localparam int RND_W           = ACC_W - COEF_FRAC;

	// Configuration port
	localparam int NUM_REGS  = 6;
	localparam int REG_IDX_W = 3;
	localparam int ADDR_W    = REG_IDX_W + 2;
	localparam int PDATA_W   = 32;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_LP_A0 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LP_B1 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_HS_A0 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_HS_A1 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_HS_B1 = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_GAIN  = 3'd5;

	// Coefficient reset values (1.0 in Q3.22 for the pass-through terms)
	localparam logic signed [COEF_W-1:0] COEF_ONE  = 26'sd4194304;
	localparam logic signed [COEF_W-1:0] COEF_ZERO = 26'sd0;

	typedef struct packed {
		logic signed [COEF_W-1:0] lp_a0;
		logic signed [COEF_W-1:0] lp_b1;
		logic signed [COEF_W-1:0] hs_a0;
		logic signed [COEF_W-1:0] hs_a1;
		logic signed [COEF_W-1:0] hs_b1;
		logic signed [COEF_W-1:0] gain;
	} scf_coefs_t;

	// Microcode fields
	typedef enum logic [2:0] {
		C_LP_A0, C_LP_B1, C_HS_A0, C_HS_A1, C_HS_B1, C_GAIN
	} coef_sel_t;

	typedef enum logic [3:0] {
		D_X0, D_X1, D_LO0, D_LO1, D_HI0, D_HI1, D_PREV0, D_PREV1, D_MIX0, D_MIX1
	} data_sel_t;

	typedef enum logic [1:0] {
		MAC_NONE, MAC_LOAD, MAC_ADD
	} mac_op_t;

	typedef enum logic [2:0] {
		WB_NONE, WB_LO0, WB_HI0, WB_LO1, WB_HI1, WB_OUT_L, WB_OUT_R
	} wb_sel_t;

	typedef enum logic [1:0] {
		SEQ_NEXT, SEQ_WAIT_IN, SEQ_WAIT_OUT
	} seq_op_t;

	localparam int NSTEPS = 16;
	localparam int STEP_W = $clog2(NSTEPS);

	typedef struct packed {
		coef_sel_t         coef;
		data_sel_t         data;
		mac_op_t           mac;
		wb_sel_t           wb;
		seq_op_t           seq;
		logic [STEP_W-1:0] target;
	} scf_ctrl_t;

	// Program for one frame. mac acts on the product in the next step;
	// wb reads the accumulator as it stands in that step.
	localparam scf_ctrl_t UCODE [NSTEPS] = '{
		'{C_GAIN,  D_X0,    MAC_NONE, WB_NONE,  SEQ_WAIT_IN,  4'd1}, // wait for a frame
		'{C_LP_A0, D_X0,    MAC_LOAD, WB_NONE,  SEQ_NEXT,     4'd0}, // left low-pass
		'{C_LP_B1, D_LO0,   MAC_ADD,  WB_NONE,  SEQ_NEXT,     4'd0},
		'{C_HS_A0, D_X0,    MAC_LOAD, WB_NONE,  SEQ_NEXT,     4'd0}, // left shelf
		'{C_HS_A1, D_PREV0, MAC_ADD,  WB_LO0,   SEQ_NEXT,     4'd0},
		'{C_HS_B1, D_HI0,   MAC_ADD,  WB_NONE,  SEQ_NEXT,     4'd0},
		'{C_LP_A0, D_X1,    MAC_LOAD, WB_NONE,  SEQ_NEXT,     4'd0}, // right low-pass
		'{C_LP_B1, D_LO1,   MAC_ADD,  WB_HI0,   SEQ_NEXT,     4'd0},
		'{C_HS_A0, D_X1,    MAC_LOAD, WB_NONE,  SEQ_NEXT,     4'd0}, // right shelf
		'{C_HS_A1, D_PREV1, MAC_ADD,  WB_LO1,   SEQ_NEXT,     4'd0},
		'{C_HS_B1, D_HI1,   MAC_ADD,  WB_NONE,  SEQ_NEXT,     4'd0},
		'{C_GAIN,  D_MIX0,  MAC_LOAD, WB_NONE,  SEQ_NEXT,     4'd0}, // left mix
		'{C_GAIN,  D_MIX0,  MAC_NONE, WB_HI1,   SEQ_NEXT,     4'd0},
		'{C_GAIN,  D_MIX1,  MAC_LOAD, WB_OUT_L, SEQ_NEXT,     4'd0}, // right mix
		'{C_GAIN,  D_MIX1,  MAC_NONE, WB_NONE,  SEQ_NEXT,     4'd0},
		'{C_GAIN,  D_MIX1,  MAC_NONE, WB_OUT_R, SEQ_WAIT_OUT, 4'd0}  // hand off result
	};

endpackage

// ===== hw/rtl/stereo_crossfeed_filter.sv =====
// Top level of the stereo crossfeed filter.
// Frames pass one at a time through the single shared multiplier, which steps
// through a 16-word microprogram; a stalled output holds the last step.
// A new frame is taken while the previous result still waits on the output.
// Reset (arst_n low, asynchronous) clears filter state and restores coefficients.
module stereo_crossfeed_filter #(
	parameter int SAMPLE_BITS = scf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [scf_pkg::ADDR_W-1:0]    paddr,
	input  logic [scf_pkg::PDATA_W-1:0]   pwdata,
	output logic [scf_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] left_sample,
	input  logic signed [SAMPLE_BITS-1:0] right_sample,
	input  logic                          frame_last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] left_result,
	output logic signed [SAMPLE_BITS-1:0] right_result,
	output logic                          result_last
);
	import scf_pkg::*;

	scf_coefs_t coefs;
	scf_ctrl_t  ctrl;
	logic       accept;
	logic       out_free;

	// Output slot can take a result when empty or leaving this cycle
	assign out_free = !out_valid || !out_stall;

	scf_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coefs   (coefs)
	);

	scf_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.in_stall (in_stall),
		.accept   (accept),
		.ctrl     (ctrl)
	);

	scf_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.coefs        (coefs),
		.accept       (accept),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.frame_last   (frame_last),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.left_result  (left_result),
		.right_result (right_result),
		.result_last  (result_last)
	);

endmodule

// ===== hw/rtl/scf_cfg_regs.sv =====
// APB-style coefficient register file.
module scf_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [scf_pkg::ADDR_W-1:0]    paddr,
	input  logic [scf_pkg::PDATA_W-1:0]   pwdata,
	output logic [scf_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output scf_pkg::scf_coefs_t           coefs
);
	import scf_pkg::*;

	logic signed [COEF_W-1:0] cfg_q [NUM_REGS];
	logic [REG_IDX_W-1:0]     idx;
	logic                     idx_ok;
	logic                     wr;

	assign idx    = paddr[ADDR_W-1:2];
	assign idx_ok = (idx < REG_IDX_W'(NUM_REGS));
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	// Register writes; indexes past the last register are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_LP_A0] <= COEF_ZERO;
			cfg_q[REG_LP_B1] <= COEF_ZERO;
			cfg_q[REG_HS_A0] <= COEF_ONE;
			cfg_q[REG_HS_A1] <= COEF_ZERO;
			cfg_q[REG_HS_B1] <= COEF_ZERO;
			cfg_q[REG_GAIN]  <= COEF_ZERO + COEF_ONE;
		end else if (wr && idx_ok) begin
			cfg_q[idx] <= pwdata[COEF_W-1:0];
		end
	end

	// Readback, sign-extended
	always_comb begin
		prdata = '0;
		if (idx_ok) begin
			prdata = PDATA_W'(cfg_q[idx]);
		end
	end

	assign coefs.lp_a0 = cfg_q[REG_LP_A0];
	assign coefs.lp_b1 = cfg_q[REG_LP_B1];
	assign coefs.hs_a0 = cfg_q[REG_HS_A0];
	assign coefs.hs_a1 = cfg_q[REG_HS_A1];
	assign coefs.hs_b1 = cfg_q[REG_HS_B1];
	assign coefs.gain  = cfg_q[REG_GAIN];

endmodule

// ===== hw/rtl/scf_sequencer.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
module scf_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 out_free,
	output logic                 in_stall,
	output logic                 accept,
	output scf_pkg::scf_ctrl_t   ctrl
);
	import scf_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;
	scf_ctrl_t         w;

	assign w        = UCODE[step_q];
	assign in_stall = (w.seq != SEQ_WAIT_IN);
	assign accept   = in_valid && (w.seq == SEQ_WAIT_IN);

	// Next step; a held step issues no write-back
	always_comb begin
		ctrl   = w;
		step_d = step_q;
		case (w.seq)
			SEQ_NEXT: begin
				step_d = step_q + 1'b1;
			end
			SEQ_WAIT_IN: begin
				if (in_valid) begin
					step_d = w.target;
				end
			end
			SEQ_WAIT_OUT: begin
				if (out_free) begin
					step_d = w.target;
				end else begin
					ctrl.wb = WB_NONE;
				end
			end
			default: begin
				step_d = step_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			step_q <= step_d;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (step_q != '0))
		else $error("frame transfer did not start the program");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(w.seq == SEQ_WAIT_OUT && !out_free) |=> (step_q == $past(step_q)))
		else $error("sequencer left the hand-off step while the output was busy");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> (ctrl.mac == MAC_NONE && ctrl.wb == WB_NONE))
		else $error("datapath active while waiting for a frame");

	a_step_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(w.seq == SEQ_NEXT) |=> (step_q == $past(step_q) + 1'b1))
		else $error("step counter skipped");

endmodule

// ===== hw/rtl/scf_datapath.sv =====
// Shared multiply-accumulate datapath, filter state and output register.
module scf_datapath #(
	parameter int SAMPLE_BITS = scf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  scf_pkg::scf_ctrl_t            ctrl,
	input  scf_pkg::scf_coefs_t           coefs,
	input  logic                          accept,
	input  logic signed [SAMPLE_BITS-1:0] left_sample,
	input  logic signed [SAMPLE_BITS-1:0] right_sample,
	input  logic                          frame_last,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic signed [SAMPLE_BITS-1:0] left_result,
	output logic signed [SAMPLE_BITS-1:0] right_result,
	output logic                          result_last
);
	import scf_pkg::*;

	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC - 1);
	localparam logic signed [RND_W-1:0] ST_MAX   = (RND_W'(1) << (STATE_W - 1)) - RND_W'(1);
	localparam logic signed [RND_W-1:0] ST_MIN   = ~ST_MAX;
	localparam logic signed [RND_W-1:0] SMP_MAX  =
		(RND_W'(1) << (SAMPLE_BITS - 1)) - RND_W'(1);
	localparam logic signed [RND_W-1:0] SMP_MIN  = ~SMP_MAX;

	logic signed [SAMPLE_BITS-1:0] x_q [2];
	logic signed [SAMPLE_BITS-1:0] prev_q [2];
	logic signed [STATE_W-1:0]     lo_q [2];
	logic signed [STATE_W-1:0]     hi_q [2];
	logic                          last_q;

	logic signed [COEF_W-1:0]      op_a;
	logic signed [MUL_B_W-1:0]     op_b;
	logic signed [PROD_W-1:0]      prod_s1;
	mac_op_t                       mac_s1;
	logic signed [ACC_W-1:0]       acc_q;
	logic signed [ACC_W-1:0]       acc_rnd;
	logic signed [RND_W-1:0]       rnd;
	logic signed [STATE_W-1:0]     state_sat;
	logic signed [SAMPLE_BITS-1:0] out_sat;

	logic signed [SAMPLE_BITS-1:0] left_hold_q;
	logic signed [SAMPLE_BITS-1:0] left_result_q;
	logic signed [SAMPLE_BITS-1:0] right_result_q;
	logic                          result_last_q;
	logic                          out_valid_q;

	// Frame capture on transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q[0] <= left_sample;
			x_q[1] <= right_sample;
			last_q <= frame_last;
		end
	end

	// Coefficient operand
	always_comb begin
		case (ctrl.coef)
			C_LP_A0: op_a = coefs.lp_a0;
			C_LP_B1: op_a = coefs.lp_b1;
			C_HS_A0: op_a = coefs.hs_a0;
			C_HS_A1: op_a = coefs.hs_a1;
			C_HS_B1: op_a = coefs.hs_b1;
			C_GAIN:  op_a = coefs.gain;
			default: op_a = coefs.gain;
		endcase
	end

	// Data operand; the mix sums are exact at 33 bits
	always_comb begin
		case (ctrl.data)
			D_X0:    op_b = MUL_B_W'(x_q[0]);
			D_X1:    op_b = MUL_B_W'(x_q[1]);
			D_LO0:   op_b = MUL_B_W'(lo_q[0]);
			D_LO1:   op_b = MUL_B_W'(lo_q[1]);
			D_HI0:   op_b = MUL_B_W'(hi_q[0]);
			D_HI1:   op_b = MUL_B_W'(hi_q[1]);
			D_PREV0: op_b = MUL_B_W'(prev_q[0]);
			D_PREV1: op_b = MUL_B_W'(prev_q[1]);
			D_MIX0:  op_b = MUL_B_W'(hi_q[0]) + MUL_B_W'(lo_q[1]);
			D_MIX1:  op_b = MUL_B_W'(hi_q[1]) + MUL_B_W'(lo_q[0]);
			default: op_b = '0;
		endcase
	end

	// Multiplier stage
	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1 <= MAC_NONE;
		end else begin
			mac_s1 <= ctrl.mac;
		end
	end

	// Accumulator
	always_ff @(posedge clk) begin
		case (mac_s1)
			MAC_LOAD: acc_q <= ACC_W'(prod_s1);
			MAC_ADD:  acc_q <= acc_q + ACC_W'(prod_s1);
			default:  acc_q <= acc_q;
		endcase
	end

	// Round half up by 22 bits, then clamp to state and sample ranges
	assign acc_rnd = acc_q + RND_HALF;
	assign rnd     = RND_W'(acc_rnd >>> COEF_FRAC);

	always_comb begin
		if (rnd > ST_MAX) begin
			state_sat = ST_MAX[STATE_W-1:0];
		end else if (rnd < ST_MIN) begin
			state_sat = ST_MIN[STATE_W-1:0];
		end else begin
			state_sat = rnd[STATE_W-1:0];
		end
		if (rnd > SMP_MAX) begin
			out_sat = SMP_MAX[SAMPLE_BITS-1:0];
		end else if (rnd < SMP_MIN) begin
			out_sat = SMP_MIN[SAMPLE_BITS-1:0];
		end else begin
			out_sat = rnd[SAMPLE_BITS-1:0];
		end
	end

	// Filter state write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q[0]   <= '0;
			lo_q[1]   <= '0;
			hi_q[0]   <= '0;
			hi_q[1]   <= '0;
			prev_q[0] <= '0;
			prev_q[1] <= '0;
		end else begin
			case (ctrl.wb)
				WB_LO0: lo_q[0] <= state_sat;
				WB_LO1: lo_q[1] <= state_sat;
				WB_HI0: begin
					hi_q[0]   <= state_sat;
					prev_q[0] <= x_q[0];
				end
				WB_HI1: begin
					hi_q[1]   <= state_sat;
					prev_q[1] <= x_q[1];
				end
				default: begin
				end
			endcase
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (ctrl.wb == WB_OUT_L) begin
			left_hold_q <= out_sat;
		end
		if (ctrl.wb == WB_OUT_R) begin
			left_result_q  <= left_hold_q;
			right_result_q <= out_sat;
			result_last_q  <= last_q;
		end
	end

	// Output valid: set on hand-off, cleared by a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.wb == WB_OUT_R) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign left_result  = left_result_q;
	assign right_result = right_result_q;
	assign result_last  = result_last_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.wb == WB_OUT_R) |-> (!out_valid_q || !out_stall))
		else $error("result overwritten while still stalled");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctrl.wb == WB_OUT_R))
		else $error("output valid without a hand-off");

	a_load_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.wb == WB_OUT_R) |-> (mac_s1 == MAC_NONE))
		else $error("accumulator moving during result hand-off");

endmodule
